[rtl/lwk_pkg.sv]
// Shared types and constants for the longest-window-with-k-marks block.
// Used by lwk_cell, lwk_chain and longest_window_at_most_k_marks.
package lwk_pkg;

  localparam int RingDepth = 256;              // most mark positions held
  localparam int IdxW      = $clog2(RingDepth);
  localparam int FillW     = IdxW + 1;         // holds 0..RingDepth
  localparam int KW        = 9;                // k_allowed register width
  localparam int PosW      = 16;
  localparam logic [PosW-1:0] MaxLen = 16'hFFFF;

  localparam int AddrW = 3;
  localparam int DataW = 32;

  // Register index taken from paddr[2].
  localparam logic [0:0] RegKAllowed = 1'b0;

  // Control broadcast along the chain of position cells.
  typedef struct packed {
    logic            shift;    // every cell not written takes its upper neighbor's value
    logic            wr_en;    // one cell takes wr_data
    logic [IdxW-1:0] wr_idx;
    logic [PosW-1:0] wr_data;
  } cell_ctl_t;

endpackage

[rtl/longest_window_at_most_k_marks.sv]
// Top level: longest window holding at most k_allowed marks, streamed.
// Depends on lwk_pkg and lwk_chain (a row of lwk_cell).
//
//   Port group   Dir   Beat carries
//   s_axis_*     in    tdata[0] = is_mark, tlast = last
//   m_axis_*     out   tdata[15:0] = longest, one beat per string
//   APB          cfg   register 0 at byte 0: k_allowed[8:0]
//
// One symbol is taken every cycle. A symbol updates the position queue and
// the window start in stage one; stage two, fed from the registers after it,
// updates the best length and, for the final symbol, loads the result
// register. Input stalls only when a final symbol reaches the second stage
// while the previous result is still held and not taken in that cycle.
// After reset the block is ready at once and k_allowed is zero.
module longest_window_at_most_k_marks (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [0] is_mark, [7:1] zero
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [15:0] longest
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lwk_pkg::AddrW-1:0] paddr,
  input  logic [lwk_pkg::DataW-1:0] pwdata,
  output logic [lwk_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import lwk_pkg::*;

  logic [KW-1:0]    k_q;
  logic [FillW-1:0] keff;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  ws_q, ws_d;
  logic [FillW-1:0] fill_q, fill_d;

  logic             s2_valid_q, s2_last_q;
  logic [PosW-1:0]  s2_end_q, s2_ws_q;
  logic [PosW-1:0]  best_q, best_d;
  logic             out_valid_q;
  logic [PosW-1:0]  out_data_q;

  logic             adv, acc, mark, s2_emit;
  logic [PosW-1:0]  pos_end, ws_new, oldest, next_start, run_len, best_new;
  logic [FillW-1:0] fill_new;
  cell_ctl_t        ctl;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegKAllowed) ? DataW'(k_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == RegKAllowed)) begin
      k_q <= pwdata[KW-1:0];
    end
  end

  assign keff = (k_q > KW'(RingDepth)) ? FillW'(RingDepth) : FillW'(k_q);

  // Handshake: hold both stages only when a result would collide.
  assign adv           = !(s2_valid_q && s2_last_q && out_valid_q && !m_axis_tready);
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;
  assign mark          = s_axis_tdata[0];

  // Stage one: position, window start and the queue of mark positions.
  assign pos_end    = (pos_q == MaxLen) ? MaxLen : pos_q + 1'b1;
  assign next_start = (oldest < pos_end) ? oldest + 1'b1 : pos_end;

  always_comb begin
    ws_new        = ws_q;
    fill_new      = fill_q;
    ctl.shift     = 1'b0;
    ctl.wr_en     = 1'b0;
    ctl.wr_idx    = fill_q[IdxW-1:0];
    ctl.wr_data   = pos_q;
    if (acc && mark) begin
      if (keff == '0) begin
        ws_new = pos_end;
      end else if (fill_q < keff) begin
        ctl.wr_en = 1'b1;
        fill_new  = fill_q + 1'b1;
      end else begin
        // Queue full for this k: drop the oldest mark, append the new one.
        ctl.shift  = 1'b1;
        ctl.wr_en  = 1'b1;
        ctl.wr_idx = IdxW'(fill_q - 1'b1);
        if (next_start > ws_q) begin
          ws_new = next_start;
        end
      end
    end
  end

  lwk_chain u_chain (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .oldest_o (oldest)
  );

  always_comb begin
    pos_d  = pos_q;
    ws_d   = ws_q;
    fill_d = fill_q;
    if (acc) begin
      pos_d  = s_axis_tlast ? '0 : pos_end;
      ws_d   = s_axis_tlast ? '0 : ws_new;
      fill_d = s_axis_tlast ? '0 : fill_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ws_q       <= '0;
      fill_q     <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      ws_q   <= ws_d;
      fill_q <= fill_d;
      if (adv) begin
        s2_valid_q <= acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s2_end_q  <= pos_end;
      s2_ws_q   <= ws_new;
      s2_last_q <= s_axis_tlast;
    end
  end

  // Stage two: window length and best length so far.
  assign run_len  = s2_end_q - s2_ws_q;
  assign best_new = (run_len > best_q) ? run_len : best_q;
  assign s2_emit  = s2_valid_q && s2_last_q && adv;

  always_comb begin
    best_d = best_q;
    if (s2_valid_q && adv) begin
      best_d = s2_last_q ? '0 : best_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      best_q <= best_d;
      if (s2_emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_emit) begin
      out_data_q <= best_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks on the block's own bookkeeping.
  a_start_le_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ws_q <= pos_q)
    else $error("window start passed the position");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(RingDepth))
    else $error("mark queue overfilled");

  a_best_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_emit |=> (best_q == '0))
    else $error("best length not cleared after a result");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

endmodule

[rtl/lwk_cell.sv]
// One cell of the mark position queue: holds one position.
// Depends on lwk_pkg for the control struct and widths.
module lwk_cell (
  input  logic                    clk_i,
  input  lwk_pkg::cell_ctl_t      ctl_i,
  input  logic [lwk_pkg::IdxW-1:0] idx_i,
  input  logic [lwk_pkg::PosW-1:0] upper_i,
  output logic [lwk_pkg::PosW-1:0] value_o
);
  import lwk_pkg::*;

  logic [PosW-1:0] value_q, value_d;

  // A write to this cell wins over the shift that moves the queue down.
  always_comb begin
    value_d = value_q;
    if (ctl_i.wr_en && (ctl_i.wr_idx == idx_i)) begin
      value_d = ctl_i.wr_data;
    end else if (ctl_i.shift) begin
      value_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

[rtl/lwk_chain.sv]
// Row of lwk_cell instances forming a queue of mark positions, oldest in cell 0.
// Depends on lwk_pkg and lwk_cell.
module lwk_chain (
  input  logic                     clk_i,
  input  lwk_pkg::cell_ctl_t       ctl_i,
  output logic [lwk_pkg::PosW-1:0] oldest_o
);
  import lwk_pkg::*;

  logic [PosW-1:0] cell_val [RingDepth];

  for (genvar g = 0; g < RingDepth; g++) begin : g_cell
    logic [PosW-1:0] upper;
    if (g == RingDepth - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_val[g+1];
    end
    lwk_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .idx_i   (IdxW'(g)),
      .upper_i (upper),
      .value_o (cell_val[g])
    );
  end

  assign oldest_o = cell_val[0];

endmodule

[tb/tb.sv]
// Self-checking testbench for longest_window_at_most_k_marks.
// Depends on lwk_pkg and the RTL top level. A scoreboard class predicts the
// longest-window result of every string and checks each output beat.

module tb;
  import lwk_pkg::*;

  typedef enum int {PACE_NONE, PACE_SRC, PACE_SNK, PACE_BOTH} pace_e;

  localparam logic [AddrW-1:0] KAllowedAddr = {RegKAllowed, 2'b00};
  localparam int unsigned      MaxLenU      = 65535;

  class window_scoreboard;
    logic [KW-1:0]   k_reg;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] win_start;
    logic [PosW-1:0] best;
    logic [PosW-1:0] mark_ring [RingDepth];
    logic [IdxW-1:0] head;
    logic [FillW-1:0] fill;
    logic [PosW-1:0] longest_q [$];
    int              errors;

    function new();
      k_reg  = '0;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      pos       = '0;
      win_start = '0;
      best      = '0;
      head      = '0;
      fill      = '0;
    endfunction

    function void mismatch(string what, int unsigned exp_v, int unsigned got_v);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
    endfunction

    function int pending();
      return longest_q.size();
    endfunction

    // One accepted symbol beat; a final symbol queues the string's answer.
    function void note_symbol(bit mark, bit last);
      int unsigned keff, cur, stop, oldest, ns, len;
      keff = (k_reg > RingDepth) ? RingDepth : k_reg;
      cur  = pos;
      stop = (cur < MaxLenU) ? cur + 1 : MaxLenU;
      if (mark) begin
        if (keff == 0) begin
          win_start = PosW'(stop);
        end else if (fill < keff) begin
          mark_ring[(head + fill) % RingDepth] = PosW'(cur);
          fill++;
        end else begin
          // Ring is full for this k: the oldest held mark leaves the window.
          oldest = mark_ring[head];
          ns = (oldest < stop) ? oldest + 1 : stop;
          if (ns > win_start) win_start = PosW'(ns);
          head++;
          mark_ring[(head + fill - 1) % RingDepth] = PosW'(cur);
        end
      end
      pos = PosW'(stop);
      if (win_start > stop) win_start = PosW'(stop);
      len = stop - win_start;
      if (len > best) best = PosW'(len);
      if (last) begin
        longest_q.push_back(best);
        clear_string();
      end
    endfunction

    function void check_result(logic [PosW-1:0] got);
      logic [PosW-1:0] want;
      if (longest_q.size() == 0) begin
        mismatch("unexpected result beat", 0, got);
      end else begin
        want = longest_q.pop_front();
        if (got !== want) mismatch("longest", want, got);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [0] is_mark, [7:1] zero
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;   // [15:0] longest
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  window_scoreboard sb;
  pace_e            pace;

  longest_window_at_most_k_marks dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver side: stall pattern follows the current pacing mode.
  always @(posedge clk_i) begin
    case (pace)
      PACE_SNK:  m_axis_tready <= ($urandom_range(99) >= 85);
      PACE_BOTH: m_axis_tready <= ($urandom_range(99) >= 8);
      default:   m_axis_tready <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_symbol(s_axis_tdata[0], s_axis_tlast);
    end
  end

  task automatic send_symbol(bit mark, bit last);
    int gap_pct;
    gap_pct = (pace == PACE_SRC) ? 85 : (pace == PACE_BOTH) ? 8 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, mark};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mark density is given in percent; the last symbol carries tlast.
  task automatic send_string(int unsigned len, int unsigned density);
    for (int unsigned i = 0; i < len; i++)
      send_symbol($urandom_range(99) < density, i == len - 1);
  endtask

  task automatic send_pattern(bit marks [$]);
    foreach (marks[i]) send_symbol(marks[i], i == marks.size() - 1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write k_allowed, then read it back in the following transfer.
  task automatic write_k(logic [KW-1:0] k);
    logic [DataW-1:0] junk;
    junk = $urandom_range(1) ? {$urandom} : '0;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KAllowedAddr;
    pwdata  <= {junk[DataW-1:KW], k};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.k_reg = k;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(DataW - KW){1'b0}}, k}) sb.mismatch("k_allowed readback", k, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned k_list [$];
    int unsigned sent;
    int unsigned len;
    int unsigned density;
    bit          deep_done;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pace          = PACE_NONE;
    sb            = new();
    deep_done     = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings with k at its reset value of zero.
    send_pattern('{1'b0});
    send_pattern('{1'b1});
    send_pattern('{1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    send_pattern('{1'b1, 1'b1, 1'b1});
    drain();
    write_k(9'd1);
    send_pattern('{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0});
    send_pattern('{1'b1, 1'b1, 1'b0, 1'b1});
    drain();

    k_list = '{2, 5, 256, 0, 511, 1, 300, 7, 0, 3};
    k_list.push_back($urandom_range(511));
    foreach (k_list[p]) begin
      pace = pace_e'(p % 4);
      write_k(k_list[p]);
      sent = 0;
      while (sent < 70) begin
        len = $urandom_range(1, 30);
        case ($urandom_range(3))
          0:       density = 0;
          1:       density = 100;
          default: density = $urandom_range(100);
        endcase
        send_string(len, density);
        sent += len;
      end
      // With a large k, send once a long, mark-dense string that can fill the ring and evict past its depth.
      if (k_list[p] >= 256 && !deep_done) begin
        send_string($urandom_range(300, 400), $urandom_range(80, 100));
        deep_done = 1'b1;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
rtl/lwk_pkg.sv
rtl/lwk_cell.sv
rtl/lwk_chain.sv
rtl/longest_window_at_most_k_marks.sv
tb/tb.sv
